[src/vbec_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vbec_pkg
// Shared types and constants of the voice block enhancement chain.
// ----------------------------------------------------------------------------
package vbec_pkg;

    localparam int SUM_W  = 38;   // block sum of squares
    localparam int MEAN_W = 32;   // mean square, at most 2^30
    localparam int ROOT_W = 16;   // integer root of the mean square
    localparam int GAIN_W = 17;   // unsigned Q3.14 gain, up to 4.0

    localparam logic signed [15:0] LP_A = 16'sd26214;  // 0.8 in Q1.15
    localparam logic signed [15:0] LP_B = 16'sd6554;   // 0.2 in Q1.15

    localparam logic [GAIN_W-1:0] AGC_ONE = 17'd16384;
    localparam logic [GAIN_W-1:0] AGC_MIN = 17'd4096;
    localparam logic [GAIN_W-1:0] AGC_MAX = 17'd65536;
    localparam logic [SUM_W-1:0]  AGC_NUM = 38'd134217728;  // 2^27

    localparam logic [6:0] VOL_FULL  = 7'd100;
    localparam logic [6:0] VOL_RESET = 7'd80;

    // floor(n / 100) = (n * DIV100_M) >> DIV100_SH for n below 2^22
    localparam logic [22:0] DIV100_M  = 23'd5368710;
    localparam int          DIV100_SH = 29;

    typedef enum logic [1:0] {
        REG_VOLUME = 2'd0,
        REG_LP_EN  = 2'd1,
        REG_ECHO_EN = 2'd2,
        REG_AGC_EN = 2'd3
    } t_reg_idx;

    typedef struct packed {
        logic               start;
        logic               lp_en;
        logic               echo_en;
        logic signed [15:0] sample;
    } t_front_req;

    typedef struct packed {
        logic               busy;
        logic               done;
        logic signed [15:0] sample;
    } t_front_rsp;

endpackage

[src/voice_block_enhance_chain_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// voice_block_enhance_chain_unit
// Low-pass, echo subtraction, block AGC and volume for 16-bit voice samples.
// ----------------------------------------------------------------------------
// Samples enter one at a time and are buffered until block_end is seen or
// BLOCK_SAMPLES are held; then the whole block leaves, AGC gain and volume
// applied. Each sample passes the accept state, the front path (multiply,
// mix with the echo line write, hand back and store) and a state that adds
// its square before the next is taken. Closing a block with AGC on runs a
// mean divide, a square root and a gain divide before the first result; the
// two divides share one divider and the root has its own unit. Each result
// then passes the store read, gain multiply, volume multiply, divide by
// hundred and output states, and waits in output for the receiver. After
// reset the echo line is swept to zero, one entry per cycle, over all
// ECHO_DELAY entries; input is held off during the sweep while register
// writes are taken. No new sample is taken while a block drains.
// ----------------------------------------------------------------------------
module voice_block_enhance_chain_unit import vbec_pkg::*; #(
    parameter int BLOCK_SAMPLES = 64,
    parameter int ECHO_DELAY    = 1024
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // input sample channel
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic signed [15:0] i_in_sample,
    input  logic               i_block_end,
    // result channel
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic signed [15:0] o_out_sample,
    output logic               o_out_last,
    // register port
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [3:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    localparam int FW = $clog2(BLOCK_SAMPLES + 1);
    localparam int AW = (BLOCK_SAMPLES > 1) ? $clog2(BLOCK_SAMPLES) : 1;
    localparam logic [FW-1:0] FILL_FULL = FW'(BLOCK_SAMPLES);

    typedef enum logic [10:0] {
        S_IDLE    = 11'b00000000001,
        S_FRONT   = 11'b00000000010,
        S_ACC     = 11'b00000000100,
        S_MEAN    = 11'b00000001000,
        S_ROOT    = 11'b00000010000,
        S_GAINDIV = 11'b00000100000,
        S_RD      = 11'b00001000000,
        S_GAIN    = 11'b00010000000,
        S_VOL     = 11'b00100000000,
        S_SCALE   = 11'b01000000000,
        S_OUT     = 11'b10000000000
    } t_state;

    // ---------------- registers ----------------
    logic [6:0] r_vol_cfg;
    logic       r_lp_en;
    logic       r_echo_en;
    logic       r_agc_en;

    t_state r_state, n_state;

    logic signed [15:0] r_store [BLOCK_SAMPLES];
    logic signed [15:0] r_rd;
    logic signed [15:0] r_x;
    logic               r_last;
    logic [FW-1:0]      r_fill;
    logic [SUM_W-1:0]   r_sum;
    logic [AW-1:0]      r_idx;
    logic [GAIN_W-1:0]  r_gain;
    logic [6:0]         r_vol;
    logic signed [33:0] r_p1;
    logic signed [23:0] r_p2;
    logic signed [15:0] r_out_sample;
    logic               r_out_last;

    // ---------------- wiring ----------------
    t_front_req w_req;
    t_front_rsp w_rsp;

    logic               w_cfg_we;
    logic               w_in_xfer;
    logic               w_out_xfer;
    logic signed [31:0] w_sq;
    logic [SUM_W-1:0]   w_sum_n;
    logic [FW-1:0]      w_fill_n;
    logic               w_close;

    logic               w_div_start;
    logic [SUM_W-1:0]   w_div_num;
    logic [15:0]        w_div_den;
    logic               w_div_done;
    logic [SUM_W-1:0]   w_quot;
    logic               w_sqrt_start;
    logic               w_sqrt_done;
    logic [ROOT_W-1:0]  w_root;
    logic [GAIN_W-1:0]  w_gain_clamp;

    logic signed [33:0] w_p1_adj;
    logic signed [19:0] w_p1_q;
    logic signed [15:0] w_agc_s;
    logic               w_p2_neg;
    logic [21:0]        w_mag;
    logic [44:0]        w_prod100;
    logic [15:0]        w_q100;
    logic               w_idx_last;

    // ---------------- register port ----------------
    assign pready   = 1'b1;
    assign w_cfg_we = psel & penable & pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vol_cfg <= VOL_RESET;
            r_lp_en   <= 1'b1;
            r_echo_en <= 1'b1;
            r_agc_en  <= 1'b1;
        end else if (w_cfg_we) begin
            unique case (t_reg_idx'(paddr[3:2]))
                REG_VOLUME:  r_vol_cfg <= pwdata[6:0];
                REG_LP_EN:   r_lp_en   <= pwdata[0];
                REG_ECHO_EN: r_echo_en <= pwdata[0];
                REG_AGC_EN:  r_agc_en  <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        prdata = '0;
        unique case (t_reg_idx'(paddr[3:2]))
            REG_VOLUME:  prdata = {25'd0, r_vol_cfg};
            REG_LP_EN:   prdata = {31'd0, r_lp_en};
            REG_ECHO_EN: prdata = {31'd0, r_echo_en};
            REG_AGC_EN:  prdata = {31'd0, r_agc_en};
            default:     prdata = '0;
        endcase
    end

    // ---------------- front path ----------------
    assign o_in_ready = (r_state == S_IDLE) && !w_rsp.busy;
    assign w_in_xfer  = i_in_valid && o_in_ready;

    assign w_req.start   = w_in_xfer;
    assign w_req.lp_en   = r_lp_en;
    assign w_req.echo_en = r_echo_en;
    assign w_req.sample  = i_in_sample;

    vbec_front #(
        .ECHO_DELAY(ECHO_DELAY)
    ) u_front (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (w_req),
        .o_rsp  (w_rsp)
    );

    // ---------------- block accumulate ----------------
    assign w_sq     = r_x * r_x;
    assign w_sum_n  = r_sum + {6'd0, w_sq};
    assign w_fill_n = r_fill + 1'b1;
    // close on the flag, or when the store is full
    assign w_close  = r_last || (w_fill_n == FILL_FULL);

    // ---------------- AGC units ----------------
    // the divider serves the mean square first, then the gain
    assign w_div_start  = ((r_state == S_ACC) && w_close && r_agc_en)
                        || ((r_state == S_ROOT) && w_sqrt_done && (w_root != '0));
    assign w_div_num    = (r_state == S_ACC) ? w_sum_n : AGC_NUM;
    assign w_div_den    = (r_state == S_ACC) ? 16'(w_fill_n) : w_root;
    assign w_sqrt_start = (r_state == S_MEAN) && w_div_done;

    vbec_div u_div (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_start(w_div_start),
        .i_num  (w_div_num),
        .i_den  (w_div_den),
        .o_done (w_div_done),
        .o_quot (w_quot)
    );

    vbec_sqrt u_sqrt (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_start(w_sqrt_start),
        .i_val  (w_quot[MEAN_W-1:0]),
        .o_done (w_sqrt_done),
        .o_root (w_root)
    );

    always_comb begin
        if (w_quot > {21'd0, AGC_MAX}) begin
            w_gain_clamp = AGC_MAX;
        end else if (w_quot < {21'd0, AGC_MIN}) begin
            w_gain_clamp = AGC_MIN;
        end else begin
            w_gain_clamp = w_quot[GAIN_W-1:0];
        end
    end

    // ---------------- drain arithmetic ----------------
    // gain product / 16384, toward zero, then saturate
    assign w_p1_adj = r_p1 + {20'd0, {14{r_p1[33]}}};
    assign w_p1_q   = w_p1_adj[33:14];
    always_comb begin
        if (w_p1_q > 20'sd32767) begin
            w_agc_s = 16'sh7fff;
        end else if (w_p1_q < -20'sd32768) begin
            w_agc_s = -16'sh8000;
        end else begin
            w_agc_s = w_p1_q[15:0];
        end
    end

    // volume product / 100 on the magnitude, by reciprocal multiply
    assign w_p2_neg  = r_p2[23];
    assign w_mag     = w_p2_neg ? 22'(-r_p2) : r_p2[21:0];
    assign w_prod100 = {23'd0, w_mag} * {22'd0, DIV100_M};
    assign w_q100    = w_prod100[DIV100_SH +: 16];

    assign w_idx_last = (FW'(r_idx) == FW'(r_fill - 1'b1));

    // ---------------- control ----------------
    assign w_out_xfer = o_out_valid && i_out_ready;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:    if (w_in_xfer) n_state = S_FRONT;
            S_FRONT:   if (w_rsp.done) n_state = S_ACC;
            S_ACC: begin
                if (!w_close) begin
                    n_state = S_IDLE;
                end else if (r_agc_en) begin
                    n_state = S_MEAN;
                end else begin
                    n_state = S_RD;
                end
            end
            S_MEAN:    if (w_div_done) n_state = S_ROOT;
            S_ROOT: begin
                if (w_sqrt_done) n_state = (w_root == '0) ? S_RD : S_GAINDIV;
            end
            S_GAINDIV: if (w_div_done) n_state = S_RD;
            S_RD:      n_state = S_GAIN;
            S_GAIN:    n_state = S_VOL;
            S_VOL:     n_state = S_SCALE;
            S_SCALE:   n_state = S_OUT;
            S_OUT: begin
                if (w_out_xfer) n_state = r_out_last ? S_IDLE : S_RD;
            end
            default:   n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_fill  <= '0;
            r_sum   <= '0;
            r_idx   <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == S_ACC) begin
                r_fill <= w_fill_n;
                r_sum  <= w_sum_n;
                r_idx  <= '0;
            end
            // advance through the block; drop it after the last transfer
            if (r_state == S_OUT && w_out_xfer) begin
                if (r_out_last) begin
                    r_fill <= '0;
                    r_sum  <= '0;
                end else begin
                    r_idx <= r_idx + 1'b1;
                end
            end
        end
    end

    // block store: written from the front path, read during the drain
    always_ff @(posedge i_clk) begin
        if (r_state == S_FRONT && w_rsp.done) r_store[r_fill[AW-1:0]] <= w_rsp.sample;
        if (r_state == S_RD) r_rd <= r_store[r_idx];
    end

    // datapath holding registers
    always_ff @(posedge i_clk) begin
        if (w_in_xfer) r_last <= i_block_end;
        if (r_state == S_FRONT && w_rsp.done) r_x <= w_rsp.sample;
        if (r_state == S_ACC && w_close) begin
            r_vol <= (r_vol_cfg > VOL_FULL) ? VOL_FULL : r_vol_cfg;
            if (!r_agc_en) r_gain <= AGC_ONE;
        end
        if (r_state == S_ROOT && w_sqrt_done && w_root == '0) r_gain <= AGC_ONE;
        if (r_state == S_GAINDIV && w_div_done) r_gain <= w_gain_clamp;
        if (r_state == S_GAIN) r_p1 <= r_rd * $signed({1'b0, r_gain});
        if (r_state == S_VOL) r_p2 <= w_agc_s * $signed({1'b0, r_vol});
        if (r_state == S_SCALE) begin
            r_out_sample <= w_p2_neg ? -$signed(w_q100) : $signed(w_q100);
            r_out_last   <= w_idx_last;
        end
    end

    assign o_out_valid  = (r_state == S_OUT);
    assign o_out_sample = r_out_sample;
    assign o_out_last   = r_out_last;

    // ---------------- checks ----------------
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_out_valid && o_in_ready))
        else $error("input taken while a block drains");

    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= FILL_FULL)
        else $error("block fill count beyond store depth");

    a_last_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_out_xfer && o_out_last) |=> !o_out_valid)
        else $error("result shown after the last of a block");

    a_gain_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RD) |-> (r_gain >= AGC_MIN && r_gain <= AGC_MAX))
        else $error("gain outside clamp range");

endmodule

[src/vbec_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vbec_front
// Per-sample low-pass and echo subtraction around the echo line memory.
// ----------------------------------------------------------------------------
module vbec_front import vbec_pkg::*; #(
    parameter int ECHO_DELAY = 1024
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_front_req i_req,
    output t_front_rsp o_rsp
);

    localparam int PW = (ECHO_DELAY > 1) ? $clog2(ECHO_DELAY) : 1;
    localparam logic [PW-1:0] PTR_LAST = PW'(ECHO_DELAY - 1);

    typedef enum logic [3:0] {
        F_CLEAR = 4'b0001,
        F_IDLE  = 4'b0010,
        F_MUL   = 4'b0100,
        F_MIX   = 4'b1000
    } t_fstate;

    t_fstate r_state, n_state;
    logic [PW-1:0]      r_ptr, n_ptr;
    logic signed [15:0] r_mem [ECHO_DELAY];
    logic signed [15:0] r_rd;
    logic signed [15:0] r_x;
    logic               r_lp_en;
    logic               r_echo_en;
    logic signed [31:0] r_acc;
    logic signed [15:0] r_y;
    logic               r_done;
    logic signed [15:0] r_out;

    logic               w_we;
    logic signed [15:0] w_wdata;
    logic signed [31:0] w_fb;
    logic signed [31:0] w_sum;
    logic signed [31:0] w_adj;
    logic signed [15:0] w_lp;
    logic signed [15:0] w_x1;
    logic signed [15:0] w_x2;

    assign w_fb  = r_y * LP_B;
    assign w_sum = r_acc + w_fb;
    // truncate toward zero: bias negative sums before the shift
    assign w_adj = w_sum + {17'd0, {15{w_sum[31]}}};
    assign w_lp  = w_adj[30:15];
    assign w_x1  = r_lp_en ? w_lp : r_x;
    assign w_x2  = r_echo_en ? (w_x1 - (r_rd >>> 2)) : w_x1;

    always_comb begin
        n_state = r_state;
        n_ptr   = r_ptr;
        w_we    = 1'b0;
        w_wdata = w_x1;
        unique case (r_state)
            F_CLEAR: begin
                w_we    = 1'b1;
                w_wdata = '0;
                if (r_ptr == PTR_LAST) begin
                    n_ptr   = '0;
                    n_state = F_IDLE;
                end else begin
                    n_ptr = r_ptr + 1'b1;
                end
            end
            F_IDLE: begin
                if (i_req.start) n_state = F_MUL;
            end
            F_MUL: n_state = F_MIX;
            F_MIX: begin
                n_state = F_IDLE;
                if (r_echo_en) begin
                    w_we  = 1'b1;
                    n_ptr = (r_ptr == PTR_LAST) ? '0 : r_ptr + 1'b1;
                end
            end
            default: n_state = F_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= F_CLEAR;
            r_ptr   <= '0;
            r_y     <= '0;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_ptr   <= n_ptr;
            r_done  <= (r_state == F_MIX);
            if (r_state == F_MIX && r_lp_en) r_y <= w_lp;
        end
    end

    // echo line: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (w_we) r_mem[r_ptr] <= w_wdata;
        if (i_req.start) r_rd <= r_mem[r_ptr];
    end

    always_ff @(posedge i_clk) begin
        if (r_state == F_IDLE && i_req.start) begin
            r_x       <= i_req.sample;
            r_lp_en   <= i_req.lp_en;
            r_echo_en <= i_req.echo_en;
        end
        if (r_state == F_MUL) r_acc <= r_x * LP_A;
        if (r_state == F_MIX) r_out <= w_x2;
    end

    assign o_rsp.busy   = (r_state == F_CLEAR);
    assign o_rsp.done   = r_done;
    assign o_rsp.sample = r_out;

endmodule

[src/vbec_div.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vbec_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module vbec_div import vbec_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [SUM_W-1:0] i_num,
    input  logic [15:0]      i_den,
    output logic             o_done,
    output logic [SUM_W-1:0] o_quot
);

    localparam int CW = $clog2(SUM_W);
    localparam logic [CW-1:0] CNT_LAST = CW'(SUM_W - 1);

    logic             r_busy;
    logic             r_done;
    logic [CW-1:0]    r_cnt;
    logic [SUM_W-1:0] r_num;
    logic [15:0]      r_den;
    logic [15:0]      r_rem;
    logic [16:0]      w_rem;
    logic [16:0]      w_diff;
    logic             w_ge;

    assign w_rem  = {r_rem, r_num[SUM_W-1]};
    assign w_diff = w_rem - {1'b0, r_den};
    assign w_ge   = (w_rem >= {1'b0, r_den});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                if (r_cnt == CNT_LAST) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
                r_cnt <= r_cnt + 1'b1;
            end
        end
    end

    // shift the quotient into the numerator register as it empties
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_num <= i_num;
            r_den <= i_den;
            r_rem <= '0;
        end else if (r_busy) begin
            r_rem <= w_ge ? w_diff[15:0] : w_rem[15:0];
            r_num <= {r_num[SUM_W-2:0], w_ge};
        end
    end

    assign o_done = r_done;
    assign o_quot = r_num;

endmodule

[src/vbec_sqrt.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vbec_sqrt
// Integer square root, one root bit per cycle.
// ----------------------------------------------------------------------------
module vbec_sqrt import vbec_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [MEAN_W-1:0] i_val,
    output logic              o_done,
    output logic [ROOT_W-1:0] o_root
);

    localparam int CW = $clog2(ROOT_W);
    localparam logic [CW-1:0] CNT_LAST = CW'(ROOT_W - 1);

    logic              r_busy;
    logic              r_done;
    logic [CW-1:0]     r_cnt;
    logic [MEAN_W-1:0] r_val;
    logic [17:0]       r_rem;
    logic [ROOT_W-1:0] r_root;
    logic [19:0]       w_rem;
    logic [19:0]       w_trial;
    logic              w_ge;

    assign w_rem   = {r_rem, r_val[MEAN_W-1 -: 2]};
    assign w_trial = {2'b00, r_root, 2'b01};
    assign w_ge    = (w_rem >= w_trial);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                if (r_cnt == CNT_LAST) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
                r_cnt <= r_cnt + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_val  <= i_val;
            r_rem  <= '0;
            r_root <= '0;
        end else if (r_busy) begin
            r_val  <= {r_val[MEAN_W-3:0], 2'b00};
            r_rem  <= w_ge ? 18'(w_rem - w_trial) : w_rem[17:0];
            r_root <= {r_root[ROOT_W-2:0], w_ge};
        end
    end

    assign o_done = r_done;
    assign o_root = r_root;

endmodule

[bench/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the voice block enhancement chain.
// ----------------------------------------------------------------------------
// Samples go in over a valid/ready channel with random gaps. A behavioral
// copy of the chain (low-pass, echo subtraction, block AGC, volume) runs
// alongside and queues the expected block of outputs whenever a block
// closes. Every output transfer is compared with the oldest queued entry.
// Register writes go through the APB port only while nothing is in flight.
// ----------------------------------------------------------------------------
module tb import vbec_pkg::*;;

    localparam int BLK     = 64;
    localparam int DLY     = 1024;
    localparam int SETTLE  = 30;    // front path drains well within this

    typedef struct {
        logic signed [15:0] sample;
        logic               last;
    } t_out_item;

    // ------------------------------------------------------------------ DUT
    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               in_valid = 1'b0;
    logic               o_in_ready;
    logic signed [15:0] in_sample = '0;
    logic               in_last = 1'b0;
    logic               o_out_valid;
    logic               out_ready = 1'b0;
    logic signed [15:0] o_out_sample;
    logic               o_out_last;
    logic               psel = 1'b0;
    logic               penable = 1'b0;
    logic               pwrite = 1'b0;
    logic [3:0]         paddr = '0;
    logic [31:0]        pwdata = '0;
    logic [31:0]        prdata;
    logic               pready;

    voice_block_enhance_chain_unit DUT (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (in_valid),
        .o_in_ready   (o_in_ready),
        .i_in_sample  (in_sample),
        .i_block_end  (in_last),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (out_ready),
        .o_out_sample (o_out_sample),
        .o_out_last   (o_out_last),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    always #2 i_clk = ~i_clk;

    // ------------------------------------------------------- chain mirror
    logic [6:0]         vol_reg   = VOL_RESET;
    logic               lp_on     = 1'b1;
    logic               echo_on   = 1'b1;
    logic               agc_on    = 1'b1;
    logic signed [15:0] lp_prev   = '0;
    logic signed [15:0] echo_hist [DLY];
    int                 echo_pos  = 0;
    logic signed [15:0] blk_buf [BLK];
    longint unsigned    energy    = 0;
    int                 blk_fill  = 0;

    t_out_item          pending_outputs[$];
    int                 errors    = 0;
    int                 samples_in = 0;
    int                 outputs_seen = 0;
    int                 blocks_closed = 0;
    bit                 idle_on   = 1'b1;   // clear for no-gap stretches

    function automatic longint unsigned int_root(longint unsigned n);
        longint unsigned root;
        longint unsigned bit_v;
        root  = 0;
        bit_v = 64'd1 << 62;
        while (bit_v > n) bit_v >>= 2;
        while (bit_v != 0) begin
            if (n >= root + bit_v) begin
                n    = n - (root + bit_v);
                root = (root >> 1) + bit_v;
            end else begin
                root = root >> 1;
            end
            bit_v >>= 2;
        end
        return root;
    endfunction

    // Advance the mirror by one accepted sample; queue a block when it closes.
    task automatic enhance_sample(logic signed [15:0] raw, logic closes);
        longint             acc;
        int                 x;
        int                 q;
        longint unsigned    rms;
        longint unsigned    gain;
        int                 vol;
        longint             s;
        t_out_item          item;
        x = raw;
        if (lp_on) begin
            acc     = 64'sd26214 * x + 64'sd6554 * lp_prev;
            x       = int'(acc / 32768);
            lp_prev = x[15:0];
        end
        if (echo_on) begin
            q = int'(echo_hist[echo_pos]) >>> 2;   // floor quarter
            echo_hist[echo_pos] = x[15:0];
            echo_pos = (echo_pos + 1) % DLY;
            x = int'($signed(16'(x - q)));
        end
        if (blk_fill >= BLK) blk_fill = 0;
        blk_buf[blk_fill] = x[15:0];
        blk_fill++;
        energy += longint'(x) * longint'(x);
        samples_in++;
        if (!closes && blk_fill < BLK) return;

        gain = 16384;
        if (agc_on) begin
            rms = int_root(energy / longint'(blk_fill));
            if (rms != 0) begin
                gain = 64'd134217728 / rms;
                if (gain > 65536) gain = 65536;
                if (gain < 4096)  gain = 4096;
            end
        end
        vol = (vol_reg > 100) ? 100 : vol_reg;
        for (int i = 0; i < blk_fill; i++) begin
            s = blk_buf[i];
            if (agc_on) begin
                s = (s * longint'(gain)) / 16384;
                if (s > 32767)  s = 32767;
                if (s < -32768) s = -32768;
            end
            s = (s * vol) / 100;
            item.sample = s[15:0];
            item.last   = (i + 1 == blk_fill);
            pending_outputs.push_back(item);
        end
        blocks_closed++;
        blk_fill = 0;
        energy   = 0;
    endtask

    // ------------------------------------------------------------- helpers
    function automatic int pick_gap();
        int r;
        if (!idle_on) return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic logic signed [15:0] pick_sample();
        case ($urandom_range(0, 9))
            0:       return 16'sh7FFF;
            1:       return 16'sh8000;
            2, 3:    return 16'($signed($urandom_range(0, 400)) - 200);
            4:       return 16'($signed($urandom_range(0, 8000)) - 4000);
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic report(string what, logic signed [15:0] got_s, logic got_l,
                          logic signed [15:0] exp_s, logic exp_l);
        errors++;
        $display("ERROR %0t: %s got sample %0d last %0b, want sample %0d last %0b",
                 $realtime, what, got_s, got_l, exp_s, exp_l);
    endtask

    // Send one sample: hold valid and payload until the transfer.
    task automatic send_sample(logic signed [15:0] s, logic closes);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_valid  <= 1'b1;
        in_sample <= s;
        in_last   <= closes;
        do @(posedge i_clk); while (!o_in_ready);
        enhance_sample(s, closes);
    endtask

    // Drop valid, then wait until every queued output is out and the front
    // path has had time to finish any sample that produced none.
    task automatic wait_quiet();
        in_valid <= 1'b0;
        while (pending_outputs.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_reg(t_reg_idx idx, logic [31:0] value);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        case (idx)
            REG_VOLUME:  vol_reg = value[6:0];
            REG_LP_EN:   lp_on   = value[0];
            REG_ECHO_EN: echo_on = value[0];
            REG_AGC_EN:  agc_on  = value[0];
        endcase
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic set_chain(logic [6:0] vol, logic lp, logic echo, logic agc);
        write_reg(REG_VOLUME, 32'(vol));
        write_reg(REG_LP_EN, 32'(lp));
        write_reg(REG_ECHO_EN, 32'(echo));
        write_reg(REG_AGC_EN, 32'(agc));
    endtask

    // ------------------------------------------------------ output side
    int stall_left = 0;
    always @(posedge i_clk) begin : ready_gen
        int g;
        if (stall_left > 0) begin
            out_ready  <= 1'b0;
            stall_left <= stall_left - 1;
        end else begin
            g = pick_gap();
            if (g == 0) begin
                out_ready <= 1'b1;
            end else begin
                out_ready  <= 1'b0;
                stall_left <= g - 1;
            end
        end
    end

    always @(posedge i_clk) begin : check_outputs
        t_out_item want;
        if (i_rst_n && o_out_valid && out_ready) begin
            outputs_seen++;
            if (pending_outputs.size() == 0) begin
                report("unexpected output", o_out_sample, o_out_last, 'x, 1'bx);
            end else begin
                want = pending_outputs.pop_front();
                if (o_out_sample !== want.sample || o_out_last !== want.last)
                    report("output", o_out_sample, o_out_last, want.sample, want.last);
            end
        end
    end

    // ---------------------------------------------------------- tests
    // Defaults after reset, extremes of the sample field, short blocks.
    task automatic test_defaults();
        send_sample(16'sh7FFF, 1'b0);
        send_sample(16'sh8000, 1'b0);
        send_sample(16'sh0000, 1'b0);
        send_sample(16'sh5555, 1'b1);
        send_sample(-16'sd1, 1'b1);          // one-sample block
        wait_quiet();
    endtask

    // Every stage bypassed; volume at full, above hundred, and zero.
    task automatic test_bypass_volume();
        set_chain(7'd100, 1'b0, 1'b0, 1'b0);
        send_sample(16'sh7FFF, 1'b0);
        send_sample(16'sh8000, 1'b1);
        wait_quiet();
        write_reg(REG_VOLUME, 32'd127);
        send_sample(16'sh8000, 1'b0);
        send_sample(16'sh2AAA, 1'b1);
        wait_quiet();
        write_reg(REG_VOLUME, 32'd0);
        send_sample(16'sh7FFF, 1'b1);
        wait_quiet();
    endtask

    // AGC alone: silent block (unity gain), quiet block (upper clamp),
    // full-scale block (lower clamp).
    task automatic test_agc_limits();
        set_chain(7'd100, 1'b0, 1'b0, 1'b1);
        send_sample(16'sd0, 1'b0);
        send_sample(16'sd0, 1'b1);
        wait_quiet();
        send_sample(16'sd3, 1'b0);
        send_sample(-16'sd5, 1'b1);
        wait_quiet();
        send_sample(16'sh8000, 1'b0);
        send_sample(16'sh8000, 1'b1);
        wait_quiet();
    endtask

    // A block that closes on count alone, no end flag anywhere.
    task automatic test_full_block();
        set_chain(7'd80, 1'b1, 1'b1, 1'b1);
        for (int i = 0; i < BLK; i++) send_sample(pick_sample(), 1'b0);
        wait_quiet();
    endtask

    // Random blocks across phases of register settings.
    task automatic test_random_blocks();
        int       sent;
        int       len;
        int       phase;
        bit       mid_change;
        sent  = 0;
        phase = 0;
        while (sent < 340) begin
            case (phase % 6)
                0: set_chain(7'd100, 1'b1, 1'b1, 1'b1);
                1: set_chain(7'd0, 1'b0, 1'b1, 1'b0);
                2: set_chain(7'd127, 1'b1, 1'b0, 1'b1);
                default: set_chain(7'($urandom_range(0, 127)), 1'($urandom),
                                   1'($urandom), 1'($urandom));
            endcase
            idle_on = (phase % 4 != 3);
            mid_change = (phase % 3 == 2);
            for (int b = 0; b < 8; b++) begin
                // Mostly moderate blocks, some single samples, some full.
                case ($urandom_range(0, 9))
                    0:       len = 1;
                    1:       len = BLK + 4;      // closes on count first
                    default: len = $urandom_range(2, 24);
                endcase
                for (int k = 0; k < len; k++) begin
                    send_sample(pick_sample(), k == len - 1 || $urandom_range(0, 40) == 0);
                    sent++;
                    // Change registers between samples of an open block.
                    if (mid_change && $urandom_range(0, 15) == 0) begin
                        wait_quiet();
                        write_reg(t_reg_idx'($urandom_range(0, 3)),
                                  32'($urandom_range(0, 127)));
                    end
                end
            end
            wait_quiet();
            phase++;
        end
        idle_on = 1'b1;
    endtask

    // ---------------------------------------------------------- sequence
    initial begin
        for (int i = 0; i < DLY; i++) echo_hist[i] = '0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_defaults();
        test_bypass_volume();
        test_agc_limits();
        test_full_block();
        test_random_blocks();
        wait_quiet();
        repeat (200) @(posedge i_clk);
        $display("Covered %0d samples in %0d blocks, %0d outputs checked.",
                 samples_in, blocks_closed, outputs_seen);
        $display("Stage bypasses, AGC clamps, volume extremes and full blocks exercised.");
        if (errors == 0 && pending_outputs.size() == 0) begin
            $display("voice_block_enhance_chain_unit: match");
        end else begin
            $display("voice_block_enhance_chain_unit: mismatch");
        end
        $finish;
    end

    initial begin
        #8ms;
        $display("Timeout with %0d outputs still queued.", pending_outputs.size());
        $display("voice_block_enhance_chain_unit: mismatch");
        $finish;
    end

endmodule
